/* rtl/roulette_wheel_selection_assert.svh */
// ----------------------------------------------------------------------------
// Roulette wheel selection assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTION_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTION_ASSERT_SVH

// same-cycle implication
`define RWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("roulette wheel selection: assertion failed");

// next-cycle implication
`define RWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("roulette wheel selection: assertion failed");

`endif

/* rtl/rws_pkg.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selection package
// Shared constants, request codes and the queued request type.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

  localparam int POP_MAX_DEF      = 256;
  localparam int FITNESS_BITS_DEF = 16;

  localparam int FIT_IN_W  = 16;   // fitness field width
  localparam int SPIN_W    = 17;   // spin field width
  localparam int SPIN_FRAC = 16;   // spin is a fraction of 2^16
  localparam int SEL_W     = 8;    // selected index width

  localparam logic [SPIN_W-1:0] SPIN_ONE = SPIN_W'(1 << SPIN_FRAC);

  localparam int S_TDATA_W = 40;   // first, fitness, spin, zero pad
  localparam int M_TDATA_W = 8;    // selected

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SPIN = 1'b1
  } cmd_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    cmd_e                kind;
    logic                first;
    logic [FIT_IN_W-1:0] fit;
    logic [SPIN_W-1:0]   spin;
  } item_t;

endpackage

`default_nettype wire

/* rtl/roulette_wheel_selection.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selection
// Fitness-proportionate parent selection over a loaded population.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects the kind: a load
//   appends fitness to the population (first restarts it at entry zero),
//   a spin picks an entry with probability proportional to its fitness.
//   Only spins produce a response on m_axis: tdata is the selected index,
//   tuser flags an empty population (index then zero).
//   Requests go into a two-deep queue, so s_axis keeps accepting while the
//   back end works or a response waits for m_axis_tready.
//   A load is handled in BK_IDLE without entering the scan. A spin first
//   forms the spin*total product, then scans the prefix RAM over the loaded
//   entries, one read per cycle, stopping at the first entry that covers the target;
//   the response is registered and shows in the cycle after the last scan step.
//   A spin waits in the queue while an earlier response is still untaken.
//   Reset empties the queue, drops any response and clears the entry count;
//   the prefix RAM is not cleared, since only loaded entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_selection #(
  parameter int POP_MAX      = rws_pkg::POP_MAX_DEF,
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] first, [16:1] fitness, [33:17] spin, [39:34] zero
  input  wire logic [rws_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] cmd: 0 load, 1 spin
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] selected
  output logic [rws_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] empty_res
  output logic                               m_axis_tuser
);

  import rws_pkg::*;

  localparam int FIT_LSB  = 1;
  localparam int SPIN_LSB = FIT_LSB + FIT_IN_W;

  logic  q_valid, q_ready;
  item_t q_item;

  // front: take requests, normalize fields, buffer two deep
  rws_front #(
    .FITNESS_BITS (FITNESS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_first_i   (s_axis_tdata[0]),
    .in_fitness_i (s_axis_tdata[FIT_LSB +: FIT_IN_W]),
    .in_spin_i    (s_axis_tdata[SPIN_LSB +: SPIN_W]),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_item_o     (q_item)
  );

  // back: prefix sum store and wheel scan, registered response
  rws_back #(
    .POP_MAX      (POP_MAX),
    .FITNESS_BITS (FITNESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sel_o   (m_axis_tdata),
    .out_empty_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/rws_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset on storage.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/rws_front.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selection front end
// Accepts requests, masks fitness, clamps spin, and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_front #(
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire rws_pkg::cmd_e                in_cmd_i,
  input  wire logic                         in_first_i,
  input  wire logic [rws_pkg::FIT_IN_W-1:0] in_fitness_i,
  input  wire logic [rws_pkg::SPIN_W-1:0]   in_spin_i,
  output logic                              q_valid_o,
  input  wire logic                         q_ready_i,
  output rws_pkg::item_t                    q_item_o
);

  import rws_pkg::*;

  localparam int FIT_W = (FITNESS_BITS < FIT_IN_W) ? FITNESS_BITS : FIT_IN_W;
  localparam logic [FIT_IN_W-1:0] FIT_MASK = FIT_IN_W'((64'd1 << FIT_W) - 64'd1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  item_t            item;
  logic             push, pop;

  // classify: first only matters on a load, spin saturates at one
  always_comb begin
    item.kind  = in_cmd_i;
    item.first = (in_cmd_i == CMD_LOAD) ? in_first_i : 1'b0;
    item.fit   = in_fitness_i & FIT_MASK;
    item.spin  = (in_spin_i > SPIN_ONE) ? SPIN_ONE : in_spin_i;
  end

  assign in_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/rws_back.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selection back end
// Appends prefix sums on loads, scans the prefix RAM on spins.
// ----------------------------------------------------------------------------
`default_nettype none

`include "roulette_wheel_selection_assert.svh"

module rws_back #(
  parameter int POP_MAX      = rws_pkg::POP_MAX_DEF,
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  output logic                           q_ready_o,
  input  wire rws_pkg::item_t            q_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [rws_pkg::SEL_W-1:0]      out_sel_o,
  output logic                           out_empty_o
);

  import rws_pkg::*;

  localparam int FIT_W  = (FITNESS_BITS < FIT_IN_W) ? FITNESS_BITS : FIT_IN_W;
  localparam int IDX_W  = $clog2(POP_MAX);
  localparam int CNT_W  = $clog2(POP_MAX + 1);
  localparam int PW     = FIT_W + IDX_W;       // prefix width
  localparam int PROD_W = PW + SPIN_W;         // spin * total width

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PW-1:0]     total_q, total_d;
  logic [PROD_W-1:0] target_q, target_d;
  logic [PW-1:0]     prev_q, prev_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic              empty_q, empty_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [PW-1:0]     ram_wdata, ram_rdata;

  logic [PW-1:0]     load_base, load_sum;
  logic [PROD_W-1:0] product, hi_ext, lo_ext;
  logic [CNT_W-1:0]  idx_nxt;
  logic              hit, last;

  rws_ram #(
    .WIDTH (PW),
    .DEPTH (POP_MAX)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    load_base = (q_item_i.first || (count_q == '0)) ? '0 : total_q;
    load_sum  = load_base + PW'(q_item_i.fit);
    product   = PROD_W'(q_item_i.spin) * PROD_W'(total_q);
    hi_ext    = PROD_W'({ram_rdata, {SPIN_FRAC{1'b0}}});
    lo_ext    = PROD_W'({prev_q, {SPIN_FRAC{1'b0}}});
    idx_nxt   = idx_q + CNT_W'(1);
    // prefixes never fall, so the first entry reaching the target decides
    hit       = (idx_q != '0) && (target_q <= hi_ext);
    last      = (idx_q == count_q - CNT_W'(1));
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    target_d    = target_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sel_d       = sel_q;
    empty_d     = empty_q;
    q_ready_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = load_sum;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.kind == CMD_LOAD) begin
            q_ready_o = 1'b1;
            // a load into a full population without restart is dropped
            if (q_item_i.first || (count_q != CNT_W'(POP_MAX))) begin
              ram_we    = 1'b1;
              ram_waddr = q_item_i.first ? '0 : count_q[IDX_W-1:0];
              total_d   = load_sum;
              count_d   = q_item_i.first ? CNT_W'(1) : count_q + CNT_W'(1);
            end
          end else if (!out_valid_q) begin
            q_ready_o = 1'b1;
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              sel_d       = '0;
              empty_d     = 1'b1;
            end else begin
              target_d  = product;
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = BK_SCAN;
            end
          end
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          out_valid_d = 1'b1;
          empty_d     = 1'b0;
          sel_d       = (hit && (lo_ext < target_q)) ? SEL_W'(idx_q) : '0;
          state_d     = BK_IDLE;
        end else begin
          prev_d    = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = idx_nxt[IDX_W-1:0];
          idx_d     = idx_nxt;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q  <= total_d;
    target_q <= target_d;
    prev_q   <= prev_d;
    idx_q    <= idx_d;
    sel_q    <= sel_d;
    empty_q  <= empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_sel_o   = sel_q;
  assign out_empty_o = empty_q;

  `RWS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(POP_MAX))
  `RWS_ASSERT_IMPL(a_scan_idx, state_q == BK_SCAN, idx_q < count_q)
  `RWS_ASSERT_IMPL(a_scan_no_out, state_q == BK_SCAN, !out_valid_q && !q_ready_o)
  `RWS_ASSERT_NEXT(a_spin_starts, (state_q == BK_IDLE) && q_ready_o && q_valid_i && (q_item_i.kind == CMD_SPIN) && (count_q != '0), state_q == BK_SCAN)

endmodule

`default_nettype wire
